[hw/rtl/cbo_pkg.sv]
// shared types and constants for the camera basis orthonormalizer
// used by camera_basis_orthonormalize_core and cbo_checker; no dependencies
package cbo_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_BITS_DEF   = 16;

  // result status codes
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_KEPT   = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CROSS,
    S_MAG,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIVI,
    S_DIV,
    S_FIN
  } state_t;

  // which vector the shared normalizer is working on
  typedef enum logic [1:0] {
    PH_FRONT,
    PH_RIGHT,
    PH_UP,
    PH_KEPT
  } phase_t;

endpackage

[hw/rtl/camera_basis_orthonormalize_core.sv]
// camera basis orthonormalizer: front/up vectors in, q1.frac right/up/front basis out
// sequence: a zero front goes straight to the result, otherwise up to 4 normalize passes of
//   (shift steps + 3 squares + 32 root steps + 3*(FRAC_BITS+3) divide steps),
//   with a cross product before each pass that needs one
// throughput: one item at a time, set by the bit-serial root and divider; in_ready only in idle
// reset: synchronous active high, clears mode to arcball and the kept basis to unit x / unit y
module camera_basis_orthonormalize_core #(
  parameter int FRAC_BITS = cbo_pkg::FRAC_BITS_DEF,
  parameter int IN_BITS   = cbo_pkg::IN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       basis_mode,
  // input item
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IN_BITS-1:0]  front_x,
  input  logic signed [IN_BITS-1:0]  front_y,
  input  logic signed [IN_BITS-1:0]  front_z,
  input  logic signed [IN_BITS-1:0]  up_x,
  input  logic signed [IN_BITS-1:0]  up_y,
  input  logic signed [IN_BITS-1:0]  up_z,
  // result item
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [FRAC_BITS+1:0] unit_front_x,
  output logic signed [FRAC_BITS+1:0] unit_front_y,
  output logic signed [FRAC_BITS+1:0] unit_front_z,
  output logic signed [FRAC_BITS+1:0] unit_right_x,
  output logic signed [FRAC_BITS+1:0] unit_right_y,
  output logic signed [FRAC_BITS+1:0] unit_right_z,
  output logic signed [FRAC_BITS+1:0] unit_up_x,
  output logic signed [FRAC_BITS+1:0] unit_up_y,
  output logic signed [FRAC_BITS+1:0] unit_up_z,
  output logic [1:0]                 status
);

  // output component width, q1.frac plus sign
  localparam int OW   = FRAC_BITS + 2;
  // vector width before normalizing: widest cross product
  localparam int VW   = FRAC_BITS + IN_BITS + 2;
  // magnitude register width, at least 31 for the normalized range
  localparam int MW   = (VW > 31) ? VW : 31;
  localparam int OPW0 = (IN_BITS > OW) ? IN_BITS : OW;
  // shared multiplier operand width, wide enough for a 31 bit square
  localparam int MOPW = (OPW0 > 32) ? OPW0 : 32;
  localparam int PW   = 2 * MOPW;
  // quotient bits and divider width
  localparam int QB   = FRAC_BITS + 2;
  localparam int DW   = FRAC_BITS + 33;
  localparam int TW   = OW + 4;
  localparam logic [OW-1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};

  cbo_pkg::state_t state, state_next;
  cbo_pkg::phase_t phase;

  logic                    mode;
  logic signed [VW-1:0]    vec  [3];
  logic signed [IN_BITS-1:0] hint [3];
  logic [MW-1:0]           m    [3];
  logic                    neg  [3];
  logic [63:0]             ssum;
  logic [63:0]             sq_r;
  logic [63:0]             sq_bit;
  logic [DW-1:0]           rem;
  logic [DW-1:0]           dvs;
  logic [QB-1:0]           quo;
  logic [1:0]              comp;
  logic [5:0]              cnt;
  logic                    uzero;
  logic signed [OW-1:0]    res  [3];
  logic signed [OW-1:0]    fv   [3];
  logic signed [OW-1:0]    rv   [3];
  logic signed [OW-1:0]    kr   [3];
  logic signed [OW-1:0]    ku   [3];
  logic signed [MOPW-1:0]  opa  [3];
  logic signed [MOPW-1:0]  opb  [3];
  logic signed [VW-1:0]    acc;

  // shared multiplier
  logic signed [MOPW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]    prod;

  logic [VW-1:0]           magv [3];
  logic                    vzero;
  logic                    too_big, in_range;
  logic [63:0]             trial;
  logic                    div_ge;
  logic [QB-1:0]           qfin;
  logic [OW-1:0]           qcap;
  logic signed [OW-1:0]    qres;
  logic [OW-1:0]           absu;
  logic [TW-1:0]           ten_u;
  logic                    guard_fail;
  logic signed [OW-1:0]    negz;
  logic                    fin_emit;
  logic                    out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == cbo_pkg::S_IDLE);
  assign out_free  = !out_valid || out_ready;

  // operand select for the multiplier: squares or cross product terms
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == cbo_pkg::S_SQ) begin
      mul_a = signed'({{(MOPW-31){1'b0}}, m[cnt[1:0]][30:0]});
      mul_b = mul_a;
    end else begin
      case (cnt[2:0])
        3'd0: begin mul_a = opa[1]; mul_b = opb[2]; end
        3'd1: begin mul_a = opa[2]; mul_b = opb[1]; end
        3'd2: begin mul_a = opa[2]; mul_b = opb[0]; end
        3'd3: begin mul_a = opa[0]; mul_b = opb[2]; end
        3'd4: begin mul_a = opa[0]; mul_b = opb[1]; end
        3'd5: begin mul_a = opa[1]; mul_b = opb[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
    prod = mul_a * mul_b;
  end

  // magnitudes, normalize tests, root and divide steps, guard
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magv[i] = vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
    end
    vzero    = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
    too_big  = ((m[0] >> 31) != '0) || ((m[1] >> 31) != '0) || ((m[2] >> 31) != '0);
    in_range = m[0][30] || m[1][30] || m[2][30];
    trial    = sq_r + sq_bit;
    div_ge   = (rem >= dvs);
    qfin     = {quo[QB-2:0], div_ge};
    qcap     = (qfin > ONE_Q) ? ONE_Q : qfin;
    qres     = neg[comp] ? -signed'(qcap) : signed'(qcap);
    absu     = res[1][OW-1] ? OW'(-res[1]) : OW'(res[1]);
    ten_u    = (TW'(absu) << 3) + (TW'(absu) << 1);
    guard_fail = !mode && (ten_u < TW'(ONE_Q));
    negz     = -res[2];
    fin_emit = ((phase == cbo_pkg::PH_FRONT) && uzero)
            || ((phase == cbo_pkg::PH_UP) && !guard_fail)
            || (phase == cbo_pkg::PH_KEPT);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cbo_pkg::S_IDLE:  if (in_valid) state_next = cbo_pkg::S_MAG;
      cbo_pkg::S_CROSS: if (cnt == 6'd5) state_next = cbo_pkg::S_MAG;
      cbo_pkg::S_MAG:   state_next = vzero ? cbo_pkg::S_FIN : cbo_pkg::S_NORM;
      cbo_pkg::S_NORM:  if (!too_big && in_range) state_next = cbo_pkg::S_SQ;
      cbo_pkg::S_SQ:    if (cnt == 6'd2) state_next = cbo_pkg::S_SQRT;
      cbo_pkg::S_SQRT:  if (cnt == 6'd31) state_next = cbo_pkg::S_DIVI;
      cbo_pkg::S_DIVI:  state_next = cbo_pkg::S_DIV;
      cbo_pkg::S_DIV: begin
        if (cnt == 6'(QB - 1)) begin
          state_next = (comp == 2'd2) ? cbo_pkg::S_FIN : cbo_pkg::S_DIVI;
        end
      end
      cbo_pkg::S_FIN: begin
        if (fin_emit) begin
          if (out_free) state_next = cbo_pkg::S_IDLE;
        end else if ((phase == cbo_pkg::PH_FRONT) && !mode) begin
          state_next = cbo_pkg::S_MAG;
        end else begin
          state_next = cbo_pkg::S_CROSS;
        end
      end
      default: state_next = cbo_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbo_pkg::S_IDLE;
      phase     <= cbo_pkg::PH_FRONT;
      mode      <= 1'b0;
      out_valid <= 1'b0;
      kr[0] <= signed'(ONE_Q); kr[1] <= '0; kr[2] <= '0;
      ku[0] <= '0; ku[1] <= signed'(ONE_Q); ku[2] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) mode <= basis_mode;
      // a new result may replace the one taken at this same edge
      if ((state == cbo_pkg::S_FIN) && fin_emit && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == cbo_pkg::S_IDLE && in_valid) phase <= cbo_pkg::PH_FRONT;
      if (state == cbo_pkg::S_FIN) begin
        case (phase)
          cbo_pkg::PH_FRONT: if (!uzero) phase <= cbo_pkg::PH_RIGHT;
          cbo_pkg::PH_RIGHT: phase <= uzero ? cbo_pkg::PH_KEPT : cbo_pkg::PH_UP;
          cbo_pkg::PH_UP: begin
            if (guard_fail) begin
              phase <= cbo_pkg::PH_KEPT;
            end else if (out_free) begin
              kr <= rv;
              ku <= res;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cbo_pkg::S_IDLE: begin
        if (in_valid) begin
          vec[0]  <= VW'(front_x);
          vec[1]  <= VW'(front_y);
          vec[2]  <= VW'(front_z);
          hint[0] <= up_x;
          hint[1] <= up_y;
          hint[2] <= up_z;
        end
      end
      cbo_pkg::S_CROSS: begin
        // even steps hold the first term, odd steps subtract the second
        if (!cnt[0]) begin
          acc <= prod[VW-1:0];
        end else begin
          vec[cnt[2:1]] <= acc - signed'(prod[VW-1:0]);
        end
        cnt <= cnt + 6'd1;
      end
      cbo_pkg::S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          m[i]   <= MW'(magv[i]);
          neg[i] <= vec[i][VW-1];
        end
        uzero <= vzero;
        if (vzero) begin
          res[0] <= '0; res[1] <= '0; res[2] <= '0;
        end
      end
      cbo_pkg::S_NORM: begin
        // one bit a cycle until the largest magnitude is in [2^30, 2^31)
        if (too_big) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (!in_range) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end else begin
          cnt  <= '0;
          ssum <= '0;
        end
      end
      cbo_pkg::S_SQ: begin
        ssum <= ssum + prod[63:0];
        if (cnt == 6'd2) begin
          cnt    <= '0;
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      cbo_pkg::S_SQRT: begin
        if (ssum >= trial) begin
          ssum <= ssum - trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + 6'd1;
        comp   <= '0;
      end
      cbo_pkg::S_DIVI: begin
        // rounded numerator m * 2^frac + n/2, divisor aligned to the top quotient bit
        rem <= (DW'(m[comp][30:0]) << FRAC_BITS) + DW'(sq_r[31:1]);
        dvs <= DW'(sq_r[31:0]) << (FRAC_BITS + 1);
        quo <= '0;
        cnt <= '0;
      end
      cbo_pkg::S_DIV: begin
        if (div_ge) rem <= rem - dvs;
        quo <= qfin;
        dvs <= dvs >> 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QB - 1)) begin
          res[comp] <= qres;
          comp      <= comp + 2'd1;
        end
      end
      cbo_pkg::S_FIN: begin
        cnt <= '0;
        case (phase)
          cbo_pkg::PH_FRONT: begin
            if (uzero) begin
              if (out_free) begin
                unit_front_x <= '0; unit_front_y <= '0; unit_front_z <= '0;
                unit_right_x <= kr[0]; unit_right_y <= kr[1]; unit_right_z <= kr[2];
                unit_up_x <= ku[0]; unit_up_y <= ku[1]; unit_up_z <= ku[2];
                status <= cbo_pkg::ST_ZERO;
              end
            end else begin
              fv <= res;
              if (!mode) begin
                // right = front cross world y
                vec[0] <= VW'(negz);
                vec[1] <= '0;
                vec[2] <= VW'(res[0]);
              end else begin
                for (int i = 0; i < 3; i++) begin
                  opa[i] <= MOPW'(res[i]);
                  opb[i] <= MOPW'(hint[i]);
                end
              end
            end
          end
          cbo_pkg::PH_RIGHT: begin
            rv <= res;
            for (int i = 0; i < 3; i++) begin
              opa[i] <= uzero ? MOPW'(ku[i]) : MOPW'(res[i]);
              opb[i] <= uzero ? MOPW'(kr[i]) : MOPW'(fv[i]);
            end
          end
          cbo_pkg::PH_UP: begin
            if (guard_fail) begin
              // near vertical: rebuild front from the kept basis
              for (int i = 0; i < 3; i++) begin
                opa[i] <= MOPW'(ku[i]);
                opb[i] <= MOPW'(kr[i]);
              end
            end else if (out_free) begin
              unit_front_x <= fv[0]; unit_front_y <= fv[1]; unit_front_z <= fv[2];
              unit_right_x <= rv[0]; unit_right_y <= rv[1]; unit_right_z <= rv[2];
              unit_up_x <= res[0]; unit_up_y <= res[1]; unit_up_z <= res[2];
              status <= cbo_pkg::ST_NORMAL;
            end
          end
          cbo_pkg::PH_KEPT: begin
            if (out_free) begin
              unit_front_x <= res[0]; unit_front_y <= res[1]; unit_front_z <= res[2];
              unit_right_x <= kr[0]; unit_right_y <= kr[1]; unit_right_z <= kr[2];
              unit_up_x <= ku[0]; unit_up_y <= ku[1]; unit_up_z <= ku[2];
              status <= cbo_pkg::ST_KEPT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/cbo_checker.sv]
// port-level checks for camera_basis_orthonormalize_core
// depends on cbo_pkg; bound to camera_basis_orthonormalize_core below
module cbo_assertions #(
  parameter int FRAC_BITS = cbo_pkg::FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [FRAC_BITS+1:0] unit_front_x,
  input logic signed [FRAC_BITS+1:0] unit_front_y,
  input logic signed [FRAC_BITS+1:0] unit_front_z,
  input logic [1:0]                  status
);

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after accept");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(unit_front_x) && $stable(status))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == cbo_pkg::ST_NORMAL || status == cbo_pkg::ST_KEPT
                  || status == cbo_pkg::ST_ZERO)
    else $error("bad status code");

  // rejected zero front reports a zero front
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cbo_pkg::ST_ZERO |->
      unit_front_x == '0 && unit_front_y == '0 && unit_front_z == '0)
    else $error("zero front status with nonzero front");

  // the front x component never exceeds one in magnitude
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_front_x <= (1 <<< FRAC_BITS) && unit_front_x >= -(1 <<< FRAC_BITS))
    else $error("front x out of range");

endmodule

bind camera_basis_orthonormalize_core cbo_assertions #(
  .FRAC_BITS(FRAC_BITS)
) u_cbo_assertions (.*);
